FILE: sv/gfu_pkg.sv
package gfu_pkg;

   localparam int POSITION_BITS_DEF = 32;
   localparam int LIMB_BITS = 32;
   localparam int MUL_LAT = 2;
   localparam int QUO_BITS = 64;
   localparam int CUTOFF_SQ_BITS = 20;

   localparam logic [63:0] STRENGTH_RESET = 64'd6155955000000;
   localparam logic [CUTOFF_SQ_BITS-1:0] CUTOFF_SQ = 20'd1000000;
   localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

FILE: sv/gfu_delay.sv
module gfu_delay #(
   parameter int W = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] dl_ff [DEPTH];

   always_ff @(posedge clock) begin
      dl_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         dl_ff[i] <= dl_ff[i-1];
      end
   end

   assign dout = dl_ff[DEPTH-1];
endmodule

FILE: sv/gfu_mul.sv
module gfu_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic               clock,
   input  logic [AW-1:0]      a,
   input  logic [BW-1:0]      b,
   output logic [AW+BW-1:0]   p
);
   import gfu_pkg::*;

   localparam int NA = (AW + LIMB_BITS - 1) / LIMB_BITS;
   localparam int NB = (BW + LIMB_BITS - 1) / LIMB_BITS;
   localparam int PW = (NA + NB) * LIMB_BITS;

   logic [NA*LIMB_BITS-1:0]  a_ext;
   logic [NB*LIMB_BITS-1:0]  b_ext;
   logic [2*LIMB_BITS-1:0]   pp_ff [NA][NB];
   logic [PW-1:0]            sum_in;
   logic [PW-1:0]            sum_ff;

   assign a_ext = (NA*LIMB_BITS)'(a);
   assign b_ext = (NB*LIMB_BITS)'(b);

   // limb partial products, then one registered sum
   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_ff[i][j] <= (2*LIMB_BITS)'(a_ext[i*LIMB_BITS +: LIMB_BITS])
                         * (2*LIMB_BITS)'(b_ext[j*LIMB_BITS +: LIMB_BITS]);
         end
      end
      sum_ff <= sum_in;
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (PW'(pp_ff[i][j]) << (LIMB_BITS * (i + j)));
         end
      end
   end

   assign p = sum_ff[AW+BW-1:0];
endmodule

FILE: sv/gfu_isqrt.sv
module gfu_isqrt #(
   parameter int RW = 130
) (
   input  logic              clock,
   input  logic [RW-1:0]     rad,
   output logic [RW/2-1:0]   root
);
   localparam int OW = RW / 2;

   logic [RW-1:0] rem_ff  [OW+1];
   logic [OW-1:0] root_ff [OW+1];

   assign rem_ff[0]  = rad;
   assign root_ff[0] = '0;

   // one result bit per stage, most significant first
   for (genvar k = 1; k <= OW; k++) begin : g_stage
      localparam int B = OW - k;
      logic [RW:0] trial;
      logic        take;
      assign trial = ((RW+1)'(root_ff[k-1]) << (B + 1)) + ((RW+1)'(1) << (2 * B));
      assign take  = (RW+1)'(rem_ff[k-1]) >= trial;
      always_ff @(posedge clock) begin
         rem_ff[k]  <= take ? rem_ff[k-1] - trial[RW-1:0] : rem_ff[k-1];
         root_ff[k] <= take ? (root_ff[k-1] | (OW'(1) << B)) : root_ff[k-1];
      end
   end

   assign root = root_ff[OW];
endmodule

FILE: sv/gfu_div.sv
module gfu_div #(
   parameter int NW = 177,
   parameter int DW = 131,
   parameter int QW = 64
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo,
   output logic          hi
);
   import gfu_pkg::*;

   localparam int CW = imax(NW, DW + QW);

   logic [CW-1:0] rem_ff [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW-1:0] quo_ff [QW+1];
   logic          hi_ff  [QW+1];

   // first stage flags a quotient that does not fit in QW bits
   always_ff @(posedge clock) begin
      rem_ff[0] <= CW'(num);
      den_ff[0] <= den;
      quo_ff[0] <= '0;
      hi_ff[0]  <= CW'(num) >= (CW'(den) << QW);
   end

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      localparam int B = QW - k;
      logic [CW-1:0] trial;
      logic          take;
      assign trial = CW'(den_ff[k-1]) << B;
      assign take  = rem_ff[k-1] >= trial;
      always_ff @(posedge clock) begin
         rem_ff[k] <= take ? rem_ff[k-1] - trial : rem_ff[k-1];
         den_ff[k] <= den_ff[k-1];
         quo_ff[k] <= take ? (quo_ff[k-1] | (QW'(1) << B)) : quo_ff[k-1];
         hi_ff[k]  <= hi_ff[k-1];
      end
   end

   assign quo = quo_ff[QW];
   assign hi  = hi_ff[QW];
endmodule

FILE: sv/pairwise_gravity_force_unit.sv
// Pairwise gravity force unit.
// Request channel: drive req_* and pulse start; a request is taken at every
// clock edge with start high and busy low. busy is always low, so one pair
// may be issued in every cycle, back to back.
// Result channel: rsp_valid is high for exactly one cycle with rsp_force_x/y/z,
// rsp_too_close and rsp_saturated. Results come out in request order.
// Throughput is one pair per cycle. The pipeline depth is set by the
// bit-serial square root stages (one root bit per stage) and the 65-stage
// restoring divider per axis.
// The receiver cannot stall: results are never held, so nothing backs up.
// Configuration: write csr_gravity_strength with csr_valid; csr_ready is
// always high. Write only while no request is in flight.
// Reset (synchronous, active high) empties the pipeline valid bits and loads
// the default strength; in-flight requests are dropped.
module pairwise_gravity_force_unit #(
   parameter int POSITION_BITS = gfu_pkg::POSITION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [POSITION_BITS-1:0] req_first_x,
   input  logic signed [POSITION_BITS-1:0] req_first_y,
   input  logic signed [POSITION_BITS-1:0] req_first_z,
   input  logic signed [POSITION_BITS-1:0] req_second_x,
   input  logic signed [POSITION_BITS-1:0] req_second_y,
   input  logic signed [POSITION_BITS-1:0] req_second_z,
   input  logic [31:0]                     req_first_mass,
   input  logic [31:0]                     req_second_mass,
   input  logic [31:0]                     req_first_radius,
   input  logic [31:0]                     req_second_radius,
   output logic                            rsp_valid,
   output logic signed [63:0]              rsp_force_x,
   output logic signed [63:0]              rsp_force_y,
   output logic signed [63:0]              rsp_force_z,
   output logic                            rsp_too_close,
   output logic                            rsp_saturated,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic signed [63:0]              csr_gravity_strength
);
   import gfu_pkg::*;

   localparam int P     = POSITION_BITS;
   localparam int FRAC  = P - 8;
   localparam int SW    = 2 * P + 2;          // sum of squares
   localparam int RADW  = SW + 64;            // radicand: S with 32 extra root bits
   localparam int RTW   = RADW / 2;           // root width
   localparam int STW   = SW + RTW;
   // net power of two between numerator and denominator
   localparam int EXPO  = 2 * FRAC + 32 - 63;
   localparam int NSH   = (EXPO > 0) ? EXPO : 0;
   localparam int DSH   = (EXPO < 0) ? -EXPO : 0;
   localparam int KMW   = 128;
   localparam int XW    = KMW + P;
   localparam int NW    = XW + NSH;
   localparam int DENW  = STW + DSH;
   // cutoff: 1e6 * S * 2^32 <= rsum^2 * 2^(2*FRAC)
   localparam int CUT_L = (2 * FRAC < 32) ? 32 - 2 * FRAC : 0;
   localparam int CUT_R = (2 * FRAC >= 32) ? 2 * FRAC - 32 : 0;
   localparam int CLW   = SW + CUTOFF_SQ_BITS + CUT_L;
   localparam int CRW   = 66 + CUT_R;
   localparam int CMW   = imax(CLW, CRW);
   // stage timing, in cycles after the input registers
   localparam int T_S   = MUL_LAT + 1;
   localparam int T_KM  = 2 * MUL_LAT;
   localparam int T_CUT = T_S + MUL_LAT;
   localparam int T_TC  = T_CUT + 1;
   localparam int T_DEN = T_S + RTW + MUL_LAT;
   localparam int T_NUM = T_KM + MUL_LAT;
   localparam int T_Q   = T_DEN + QUO_BITS + 1;
   localparam int T_OUT = T_Q + 1;

   logic               accept;
   logic [T_OUT:0]     vld_ff;
   logic [63:0]        strength_ff;
   logic               kneg;
   logic [63:0]        kmag;

   logic signed [P-1:0] first_pos [3];
   logic signed [P-1:0] second_pos [3];
   logic [P-1:0]       mag_ff [3];
   logic [2:0]         neg_ff;
   logic [32:0]        rsum_ff;
   logic [31:0]        m1_ff;
   logic [31:0]        m2_ff;

   logic [2*P-1:0]     sq [3];
   logic [SW-1:0]      s_ff;
   logic [65:0]        rsq;
   logic [65:0]        rsq_d;
   logic [SW+CUTOFF_SQ_BITS-1:0] scut;
   logic               tc_ff;
   logic               tc_d;
   logic [63:0]        mm;
   logic [KMW-1:0]     km;
   logic [3*P-1:0]     mag_d;
   logic [RTW-1:0]     root;
   logic [SW-1:0]      s_d;
   logic [STW-1:0]     st;
   logic [DENW-1:0]    den;
   logic [2:0]         neg_d;

   logic [XW-1:0]      num [3];
   logic [NW-1:0]      num_d [3];
   logic [63:0]        quo [3];
   logic               hi [3];
   logic [63:0]        force_in [3];
   logic [2:0]         over;
   logic [63:0]        force_ff [3];
   logic               sat_ff;
   logic               close_ff;

   assign accept    = start && !busy;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // strength register; magnitude and sign split for the unsigned datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= STRENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         strength_ff <= csr_gravity_strength;
      end
   end

   assign kneg = strength_ff[63];
   assign kmag = kneg ? (64'd0 - strength_ff) : strength_ff;

   // valid bits follow each request down the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[T_OUT-1:0], accept};
      end
   end

   assign first_pos[0]  = req_first_x;
   assign first_pos[1]  = req_first_y;
   assign first_pos[2]  = req_first_z;
   assign second_pos[0] = req_second_x;
   assign second_pos[1] = req_second_y;
   assign second_pos[2] = req_second_z;

   // input stage: axis differences as sign and magnitude, radius sum
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         logic signed [P:0] diff;
         diff = (P+1)'(first_pos[i]) - (P+1)'(second_pos[i]);
         mag_ff[i] <= diff[P] ? P'(-diff) : P'(diff);
         neg_ff[i] <= diff[P] ^ kneg;
      end
      rsum_ff <= 33'(req_first_radius) + 33'(req_second_radius);
      m1_ff   <= req_first_mass;
      m2_ff   <= req_second_mass;
   end

   for (genvar i = 0; i < 3; i++) begin : g_sq
      gfu_mul #(.AW(P), .BW(P)) u_sq (
         .clock (clock), .a (mag_ff[i]), .b (mag_ff[i]), .p (sq[i])
      );
   end

   always_ff @(posedge clock) begin
      s_ff <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
   end

   // cutoff test path
   gfu_mul #(.AW(33), .BW(33)) u_rsq (
      .clock (clock), .a (rsum_ff), .b (rsum_ff), .p (rsq)
   );

   gfu_delay #(.W(66), .DEPTH(T_CUT - MUL_LAT)) u_rsq_dly (
      .clock (clock), .din (rsq), .dout (rsq_d)
   );

   gfu_mul #(.AW(SW), .BW(CUTOFF_SQ_BITS)) u_scut (
      .clock (clock), .a (s_ff), .b (CUTOFF_SQ), .p (scut)
   );

   always_ff @(posedge clock) begin
      tc_ff <= (CMW'(scut) << CUT_L) <= (CMW'(rsq_d) << CUT_R);
   end

   // numerator constant: |k| * m1 * m2
   gfu_mul #(.AW(32), .BW(32)) u_mm (
      .clock (clock), .a (m1_ff), .b (m2_ff), .p (mm)
   );

   gfu_mul #(.AW(64), .BW(64)) u_km (
      .clock (clock), .a (kmag), .b (mm), .p (km)
   );

   gfu_delay #(.W(3*P), .DEPTH(T_KM)) u_mag_dly (
      .clock (clock), .din ({mag_ff[2], mag_ff[1], mag_ff[0]}), .dout (mag_d)
   );

   // denominator: S * sqrt(S * 2^64)
   gfu_isqrt #(.RW(RADW)) u_sqrt (
      .clock (clock), .rad ({s_ff, 64'd0}), .root (root)
   );

   gfu_delay #(.W(SW), .DEPTH(RTW)) u_s_dly (
      .clock (clock), .din (s_ff), .dout (s_d)
   );

   gfu_mul #(.AW(SW), .BW(RTW)) u_st (
      .clock (clock), .a (s_d), .b (root), .p (st)
   );

   assign den = DENW'(st) << DSH;

   gfu_delay #(.W(3), .DEPTH(T_Q)) u_neg_dly (
      .clock (clock), .din (neg_ff), .dout (neg_d)
   );

   gfu_delay #(.W(1), .DEPTH(T_Q - T_TC)) u_tc_dly (
      .clock (clock), .din (tc_ff), .dout (tc_d)
   );

   for (genvar i = 0; i < 3; i++) begin : g_axis
      gfu_mul #(.AW(KMW), .BW(P)) u_num (
         .clock (clock), .a (km), .b (mag_d[i*P +: P]), .p (num[i])
      );

      gfu_delay #(.W(NW), .DEPTH(T_DEN - T_NUM)) u_num_dly (
         .clock (clock), .din (NW'(num[i]) << NSH), .dout (num_d[i])
      );

      gfu_div #(.NW(NW), .DW(DENW), .QW(QUO_BITS)) u_div (
         .clock (clock), .num (num_d[i]), .den (den), .quo (quo[i]), .hi (hi[i])
      );

      // clamp to the signed range, then apply the sign
      always_comb begin
         logic [63:0] lim;
         logic [63:0] mag_c;
         lim     = neg_d[i] ? NEG_LIMIT : POS_LIMIT;
         over[i] = hi[i] || (quo[i] > lim);
         mag_c   = over[i] ? lim : quo[i];
         force_in[i] = neg_d[i] ? (64'd0 - mag_c) : mag_c;
      end
   end

   // output register; a too-close pair forces zero and drops the clamp flag
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         force_ff[i] <= tc_d ? 64'd0 : force_in[i];
      end
      sat_ff   <= !tc_d && (|over);
      close_ff <= tc_d;
   end

   assign rsp_valid     = vld_ff[T_OUT];
   assign rsp_force_x   = force_ff[0];
   assign rsp_force_y   = force_ff[1];
   assign rsp_force_z   = force_ff[2];
   assign rsp_too_close = close_ff;
   assign rsp_saturated = sat_ff;
endmodule
